// ===== rtl/qau_pkg.sv =====
// Shared types, widths and arithmetic helpers of the quaternion arithmetic unit.
package qau_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int CMD_W      = 2;
  localparam int BLEND_W    = FRAC_BITS + 1;

  localparam logic [CMD_W-1:0] CMD_PROD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BLEND = 2'd2;

  // Datapath widths.
  localparam int PW       = 2 * COMP_WIDTH;           // component product
  localparam int SUM_W    = PW + 2;                   // sum of four products
  localparam int VW       = SUM_W - FRAC_BITS;        // rounded intermediate component
  localparam int BP_W     = COMP_WIDTH + FRAC_BITS + 2; // component times weight
  localparam int TP_W     = VW + COMP_WIDTH;          // rotate second-stage product
  localparam int TS_W     = TP_W + 2;                 // widest signed sum
  localparam int SQ_W     = 2 * VW;                   // one square
  localparam int SW       = 2 * VW + 2;               // sum of squares
  localparam int SQ_STEPS = SW / 2;
  localparam int QW       = FRAC_BITS + 1;            // normalized magnitude bits
  localparam int NW       = VW + FRAC_BITS + 2;       // divider remainder
  localparam int CNT_W    = $clog2(SQ_STEPS + 1);

  localparam int QDEPTH       = 8;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int FRONT_STAGES = 4;
  localparam int FLY_W        = $clog2(FRONT_STAGES + 1);
  localparam int OCC_W        = $clog2(QDEPTH + FRONT_STAGES + 1);

  localparam logic [BLEND_W-1:0] ONE_W = BLEND_W'(1) << FRAC_BITS;
  localparam logic [TS_W:0] HALF = (TS_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [TS_W-1:0] SAT_HI = (TS_W'(1) << (COMP_WIDTH - 1)) - TS_W'(1);
  localparam logic signed [TS_W-1:0] SAT_LO = -SAT_HI - TS_W'(1);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    comp_t              a_x;
    comp_t              a_y;
    comp_t              a_z;
    comp_t              a_w;
    comp_t              b_x;
    comp_t              b_y;
    comp_t              b_z;
    comp_t              b_w;
    logic [BLEND_W-1:0] blend;
  } item_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  zero_norm;
    logic  clipped;
  } result_t;

  // One classified item between the front and the back.
  typedef struct packed {
    logic               pass;   // result is final, no normalization needed
    result_t            res;
    logic [3:0][VW-1:0] v;      // components to normalize
    logic [SW-1:0]      sumsq;
  } q_entry_t;

  // Shift right by FRAC_BITS, rounding half away from zero.
  function automatic logic signed [TS_W-1:0] shr_round(input logic signed [TS_W-1:0] x);
    logic [TS_W:0] mag;
    logic [TS_W:0] r;
    mag = x[TS_W-1] ? ((TS_W + 1)'(~x) + (TS_W + 1)'(1)) : (TS_W + 1)'(x);
    r   = (mag + HALF) >> FRAC_BITS;
    return x[TS_W-1] ? -$signed(r[TS_W-1:0]) : $signed(r[TS_W-1:0]);
  endfunction

  function automatic comp_t sat_val(input logic signed [TS_W-1:0] x);
    logic signed [TS_W-1:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    if (x < SAT_LO) y = SAT_LO;
    return comp_t'(y[COMP_WIDTH-1:0]);
  endfunction

  function automatic logic sat_hit(input logic signed [TS_W-1:0] x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

endpackage

// ===== rtl/qau_front.sv =====
// Front pipeline: products, sums and rounding; classifies each item for the back.
module qau_front
  import qau_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  item_t            item,
  output logic             entry_valid,
  output q_entry_t         entry,
  output logic [FLY_W-1:0] inflight
);

  comp_t a [4];
  comp_t b [4];
  logic [BLEND_W-1:0] wt_t;
  logic [BLEND_W-1:0] wt_u;

  logic                    v1, v2, v3;
  logic [CMD_W-1:0]        cmd1, cmd2, cmd3;
  logic signed [PW-1:0]    p1 [4][4];
  logic signed [BP_W-1:0]  ba1 [4];
  logic signed [BP_W-1:0]  bb1 [4];
  comp_t                   b1 [4];
  comp_t                   b2 [4];
  logic signed [VW-1:0]    v2v [4];
  logic signed [VW-1:0]    v3v [4];
  logic signed [TP_W-1:0]  pq3 [4][4];
  logic [SQ_W-1:0]         sq3 [4];

  logic signed [SUM_W-1:0] sum2 [4];
  logic signed [TS_W-1:0]  rsum [3];
  logic signed [TS_W-1:0]  rrnd [3];

  assign a[0] = item.a_x;
  assign a[1] = item.a_y;
  assign a[2] = item.a_z;
  assign a[3] = item.a_w;
  assign b[0] = item.b_x;
  assign b[1] = item.b_y;
  assign b[2] = item.b_z;
  assign b[3] = item.b_w;
  assign wt_t = (item.blend > ONE_W) ? ONE_W : item.blend;
  assign wt_u = ONE_W - wt_t;

  // Stage 1: every a_i * b_j, and the blend weights applied.
  always_ff @(posedge clk) begin
    cmd1 <= item.cmd;
    for (int i = 0; i < 4; i++) begin
      b1[i]  <= b[i];
      ba1[i] <= BP_W'(a[i]) * $signed({2'b00, wt_u});
      bb1[i] <= BP_W'(b[i]) * $signed({2'b00, wt_t});
      for (int j = 0; j < 4; j++) begin
        p1[i][j] <= PW'(a[i]) * PW'(b[j]);
      end
    end
  end

  // Stage 2: Hamilton product, first rotate half, or blend, then rounding.
  always_comb begin
    for (int i = 0; i < 4; i++) sum2[i] = '0;
    case (cmd1)
      CMD_PROD: begin
        sum2[0] = SUM_W'(p1[3][0]) + SUM_W'(p1[0][3]) + SUM_W'(p1[1][2]) - SUM_W'(p1[2][1]);
        sum2[1] = SUM_W'(p1[3][1]) + SUM_W'(p1[1][3]) + SUM_W'(p1[2][0]) - SUM_W'(p1[0][2]);
        sum2[2] = SUM_W'(p1[3][2]) + SUM_W'(p1[2][3]) + SUM_W'(p1[0][1]) - SUM_W'(p1[1][0]);
        sum2[3] = SUM_W'(p1[3][3]) - SUM_W'(p1[0][0]) - SUM_W'(p1[1][1]) - SUM_W'(p1[2][2]);
      end
      CMD_ROT: begin
        sum2[0] = SUM_W'(p1[0][3]) + SUM_W'(p1[2][1]) - SUM_W'(p1[1][2]);
        sum2[1] = SUM_W'(p1[1][3]) + SUM_W'(p1[0][2]) - SUM_W'(p1[2][0]);
        sum2[2] = SUM_W'(p1[2][3]) + SUM_W'(p1[1][0]) - SUM_W'(p1[0][1]);
        sum2[3] = SUM_W'(p1[0][0]) + SUM_W'(p1[1][1]) + SUM_W'(p1[2][2]);
      end
      CMD_BLEND: begin
        for (int i = 0; i < 4; i++) sum2[i] = SUM_W'(ba1[i]) + SUM_W'(bb1[i]);
      end
      default: begin
        for (int i = 0; i < 4; i++) sum2[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd2 <= cmd1;
    for (int i = 0; i < 4; i++) begin
      b2[i]  <= b1[i];
      v2v[i] <= VW'(shr_round(TS_W'(sum2[i])));
    end
  end

  // Stage 3: rotate second-half products and the squares for the norm.
  always_ff @(posedge clk) begin
    cmd3 <= cmd2;
    for (int i = 0; i < 4; i++) begin
      v3v[i] <= v2v[i];
      sq3[i] <= $unsigned(SQ_W'(v2v[i]) * SQ_W'(v2v[i]));
      for (int j = 0; j < 4; j++) begin
        pq3[i][j] <= TP_W'(v2v[i]) * TP_W'(b2[j]);
      end
    end
  end

  // Stage 4: finish rotate, or hand the components over for normalizing.
  always_comb begin
    rsum[0] = TS_W'(pq3[3][0]) + TS_W'(pq3[0][3]) - TS_W'(pq3[1][2]) + TS_W'(pq3[2][1]);
    rsum[1] = TS_W'(pq3[3][1]) + TS_W'(pq3[1][3]) - TS_W'(pq3[2][0]) + TS_W'(pq3[0][2]);
    rsum[2] = TS_W'(pq3[3][2]) + TS_W'(pq3[2][3]) - TS_W'(pq3[0][1]) + TS_W'(pq3[1][0]);
    for (int k = 0; k < 3; k++) rrnd[k] = shr_round(rsum[k]);
  end

  always_ff @(posedge clk) begin
    entry.pass  <= (cmd3 != CMD_PROD) && (cmd3 != CMD_BLEND);
    entry.sumsq <= SW'(sq3[0]) + SW'(sq3[1]) + SW'(sq3[2]) + SW'(sq3[3]);
    for (int i = 0; i < 4; i++) entry.v[i] <= v3v[i];
    if (cmd3 == CMD_ROT) begin
      entry.res.r_x       <= sat_val(rrnd[0]);
      entry.res.r_y       <= sat_val(rrnd[1]);
      entry.res.r_z       <= sat_val(rrnd[2]);
      entry.res.r_w       <= '0;
      entry.res.zero_norm <= 1'b0;
      entry.res.clipped   <= sat_hit(rrnd[0]) | sat_hit(rrnd[1]) | sat_hit(rrnd[2]);
    end else begin
      entry.res <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      entry_valid <= 1'b0;
    end else begin
      v1          <= accept;
      v2          <= v1;
      v3          <= v2;
      entry_valid <= v3;
    end
  end

  assign inflight = FLY_W'(v1) + FLY_W'(v2) + FLY_W'(v3) + FLY_W'(entry_valid);

endmodule

// ===== rtl/qau_queue.sv =====
// Short FIFO of classified items between the front and the back.
module qau_queue
  import qau_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  q_entry_t          din,
  input  logic              pop,
  output q_entry_t          dout,
  output logic [QCNT_W-1:0] count
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign dout = slots[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH)) || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/qau_back.sv =====
// Back end: square root and four-lane division for normalizing, result register.
module qau_back
  import qau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     pop,
  output logic     done,
  output result_t  result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [SW-1:0]    rem;
  logic [SW-1:0]    root;
  logic [SW-1:0]    sbit;
  logic [3:0]       neg;
  logic [VW-1:0]    mag [4];
  logic [NW-1:0]    num [4];
  logic [NW-1:0]    dvs;
  logic [QW-1:0]    quo [4];

  logic [SW-1:0]    sq_try;
  logic             sq_ge;
  logic [SW-1:0]    root_next;
  logic [SW-1:0]    rem_next;
  logic [3:0]       dv_ge;
  logic [QW-1:0]    quo_next [4];
  logic signed [TS_W-1:0] lane_val [4];

  assign pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    sq_try    = root + sbit;
    sq_ge     = rem >= sq_try;
    root_next = sq_ge ? ((root >> 1) + sbit) : (root >> 1);
    rem_next  = sq_ge ? (rem - sq_try) : rem;
    for (int i = 0; i < 4; i++) begin
      dv_ge[i]    = num[i] >= dvs;
      quo_next[i] = {quo[i][QW-2:0], dv_ge[i]};
      lane_val[i] = neg[i] ? -$signed(TS_W'(quo_next[i])) : $signed(TS_W'(quo_next[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.pass) begin
              done <= 1'b1;
            end else if (q_head.sumsq == '0) begin
              done <= 1'b1;
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (cnt == CNT_W'(1)) state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.pass) begin
            result <= q_head.res;
          end else if (q_head.sumsq == '0) begin
            result           <= '0;
            result.zero_norm <= 1'b1;
          end
        end
        rem  <= q_head.sumsq;
        root <= '0;
        sbit <= SW'(1) << (SW - 2);
        cnt  <= CNT_W'(SQ_STEPS);
        for (int i = 0; i < 4; i++) begin
          neg[i] <= q_head.v[i][VW-1];
          mag[i] <= q_head.v[i][VW-1] ? (~q_head.v[i] + VW'(1)) : q_head.v[i];
        end
      end
      ST_SQRT: begin
        rem  <= rem_next;
        root <= root_next;
        sbit <= sbit >> 2;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          // Root is complete: set up each lane's rounded quotient.
          dvs <= NW'(root_next) << (QW - 1);
          cnt <= CNT_W'(QW);
          for (int i = 0; i < 4; i++) begin
            num[i] <= (NW'(mag[i]) << FRAC_BITS) + NW'(root_next >> 1);
            quo[i] <= '0;
          end
        end
      end
      ST_DIV: begin
        dvs <= dvs >> 1;
        cnt <= cnt - CNT_W'(1);
        for (int i = 0; i < 4; i++) begin
          quo[i] <= quo_next[i];
          if (dv_ge[i]) num[i] <= num[i] - dvs;
        end
        if (cnt == CNT_W'(1)) begin
          result.r_x       <= sat_val(lane_val[0]);
          result.r_y       <= sat_val(lane_val[1]);
          result.r_z       <= sat_val(lane_val[2]);
          result.r_w       <= sat_val(lane_val[3]);
          result.zero_norm <= 1'b0;
          result.clipped   <= sat_hit(lane_val[0]) | sat_hit(lane_val[1]) |
                              sat_hit(lane_val[2]) | sat_hit(lane_val[3]);
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/quaternion_arith_unit.sv =====
// Top level of the quaternion arithmetic unit.
// An item is taken when start is high and busy is low; its result appears for one
// cycle with done high, in the order the items were taken, and cannot be held off.
// The front pipeline takes one item per cycle while its eight-entry queue has room.
// Rotate (and the unused command) and a product or blend with a zero sum of squares
// go straight to the result register once the back end is idle with them at the
// queue head. Other products and blends are normalized (Q1.14) by a shared back
// end, a two-bit-per-cycle square root then four one-bit-per-cycle dividers, which
// takes no new item until the last is through. Rotate thus sustains one item per
// cycle while no normalized item is ahead. There is no clearing pass after reset.
module quaternion_arith_unit
  import qau_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic              accept;
  logic              entry_valid;
  q_entry_t          entry;
  logic [FLY_W-1:0]  inflight;
  q_entry_t          q_head;
  logic [QCNT_W-1:0] q_count;
  logic              pop;

  // Every beat in the front pipeline already owns a queue slot.
  assign busy   = (OCC_W'(q_count) + OCC_W'(inflight)) >= OCC_W'(QDEPTH);
  assign accept = start && !busy;

  qau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .entry_valid(entry_valid),
    .entry      (entry),
    .inflight   (inflight)
  );

  qau_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (entry_valid),
    .din  (entry),
    .pop  (pop),
    .dout (q_head),
    .count(q_count)
  );

  qau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_count != '0),
    .q_head (q_head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
